// ----- rtl/spq_pkg.sv -----
// Shared constants and types for the stable sorted priority queue
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W    = 8;
	localparam int TAG_W    = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 5;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef struct packed {
		logic ins;
		logic rem;
	} spq_ctrl_t;

endpackage

// ----- rtl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry, shifts right on insert, left on remove
module spq_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spq_pkg::spq_ctrl_t            ctrl,
	input  logic [spq_pkg::KEY_W-1:0]     new_key,
	input  logic [spq_pkg::TAG_W-1:0]     new_tag,
	input  logic                          left_keep,
	input  logic                          left_valid,
	input  logic [spq_pkg::KEY_W-1:0]     left_key,
	input  logic [spq_pkg::TAG_W-1:0]     left_tag,
	input  logic                          right_valid,
	input  logic [spq_pkg::KEY_W-1:0]     right_key,
	input  logic [spq_pkg::TAG_W-1:0]     right_tag,
	output logic                          keep,
	output logic                          valid,
	output logic [spq_pkg::KEY_W-1:0]     key,
	output logic [spq_pkg::TAG_W-1:0]     tag
);

	logic                      valid_q;
	logic [spq_pkg::KEY_W-1:0] key_q;
	logic [spq_pkg::TAG_W-1:0] tag_q;

	// entries ahead of the new one stay put; equal keys stay ahead
	assign keep  = valid_q && (key_q >= new_key);
	assign valid = valid_q;
	assign key   = key_q;
	assign tag   = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins && !keep) begin
			valid_q <= left_keep ? 1'b1 : left_valid;
		end else if (ctrl.rem) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && !keep) begin
			key_q <= left_keep ? new_key : left_key;
			tag_q <= left_keep ? new_tag : left_tag;
		end else if (ctrl.rem) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end
	end

endmodule

// ----- rtl/stable_sorted_priority_queue_core.sv -----
// Top level: chain of sorted cells, entry count and registered result
// Result strobe (done) is registered: it rises in the cycle after the request is taken.
// Throughput: one insert or remove per cycle; busy stays low, the cell chain
// reorders in the same cycle the request is taken.
// Reset: arst_n clears all cell valid bits, the count and done; queue empty.
// The receiver cannot stall: each result shows for exactly one cycle.
module stable_sorted_priority_queue_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [spq_pkg::KEY_W-1:0]     key,
	input  logic [spq_pkg::TAG_W-1:0]     item_tag,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [spq_pkg::KEY_W-1:0]     out_key,
	output logic [spq_pkg::TAG_W-1:0]     out_tag,
	output logic [spq_pkg::OCC_W-1:0]     occupancy
);

	localparam int N = spq_pkg::CAPACITY;

	logic [spq_pkg::CNT_W-1:0] count_q;
	logic [spq_pkg::CNT_W-1:0] count_d;
	logic                      done_q;
	spq_pkg::status_t          status_q;
	spq_pkg::status_t          status_d;
	logic [spq_pkg::KEY_W-1:0] out_key_q;
	logic [spq_pkg::TAG_W-1:0] out_tag_q;
	logic [spq_pkg::OCC_W-1:0] occ_q;
	spq_pkg::spq_ctrl_t        ctrl;
	logic                      take;
	logic                      is_empty;
	logic                      is_full;

	logic                      c_keep  [N];
	logic                      c_valid [N];
	logic [spq_pkg::KEY_W-1:0] c_key   [N];
	logic [spq_pkg::TAG_W-1:0] c_tag   [N];

	assign busy     = 1'b0;
	assign take     = start && !busy;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == spq_pkg::CNT_W'(N));

	always_comb begin
		ctrl     = '0;
		count_d  = count_q;
		status_d = spq_pkg::ST_OK;
		if (func == spq_pkg::FUNC_REMOVE) begin
			if (is_empty) begin
				status_d = spq_pkg::ST_EMPTY;
			end else begin
				ctrl.rem = take;
				count_d  = count_q - spq_pkg::CNT_W'(1);
			end
		end else begin
			if (is_full) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				ctrl.ins = take;
				count_d  = count_q + spq_pkg::CNT_W'(1);
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic                      lk;
		logic                      lv;
		logic [spq_pkg::KEY_W-1:0] lkey;
		logic [spq_pkg::TAG_W-1:0] ltag;
		logic                      rv;
		logic [spq_pkg::KEY_W-1:0] rkey;
		logic [spq_pkg::TAG_W-1:0] rtag;

		if (i == 0) begin : g_head
			assign lk   = 1'b1;
			assign lv   = 1'b0;
			assign lkey = '0;
			assign ltag = '0;
		end else begin : g_mid
			assign lk   = c_keep[i-1];
			assign lv   = c_valid[i-1];
			assign lkey = c_key[i-1];
			assign ltag = c_tag[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign rv   = 1'b0;
			assign rkey = '0;
			assign rtag = '0;
		end else begin : g_body
			assign rv   = c_valid[i+1];
			assign rkey = c_key[i+1];
			assign rtag = c_tag[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_key     (key),
			.new_tag     (item_tag),
			.left_keep   (lk),
			.left_valid  (lv),
			.left_key    (lkey),
			.left_tag    (ltag),
			.right_valid (rv),
			.right_key   (rkey),
			.right_tag   (rtag),
			.keep        (c_keep[i]),
			.valid       (c_valid[i]),
			.key         (c_key[i]),
			.tag         (c_tag[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= take;
			if (take) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q  <= status_d;
			occ_q     <= spq_pkg::OCC_W'(count_d);
			out_key_q <= ctrl.rem ? c_key[0] : '0;
			out_tag_q <= ctrl.rem ? c_tag[0] : '0;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign out_key   = out_key_q;
	assign out_tag   = out_tag_q;
	assign occupancy = occ_q;

endmodule
